// ----- rtl/ldtd_pkg.sv -----
// ldtd_pkg: shared constants, register indexes and Q16.16 helpers for the beam deskew block
// used by ldtd_cordic and lidar_beam_twist_deskew_top; depends on nothing else
package ldtd_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_LIN_VEL        = 3'd0;
	localparam logic [2:0] REG_ANG_VEL        = 3'd1;
	localparam logic [2:0] REG_START_X        = 3'd2;
	localparam logic [2:0] REG_START_Y        = 3'd3;
	localparam logic [2:0] REG_START_HEADING  = 3'd4;
	localparam logic [2:0] REG_SENSOR_HEADING = 3'd5;
	localparam logic [2:0] REG_SENSOR_X       = 3'd6;
	localparam logic [2:0] REG_SENSOR_Y       = 3'd7;

	// beams at or beyond this range are invalid
	localparam logic [30:0] MAX_RANGE = 31'd1966080;

	// series coefficients in Q16.16
	localparam logic signed [31:0] Q_ONE   = 32'sd65536;
	localparam logic signed [31:0] Q_HALF  = 32'sd32768;
	localparam logic signed [31:0] C_M6    = -32'sd10923;
	localparam logic signed [31:0] C_M6X2  = -32'sd21846;
	localparam logic signed [31:0] C_M24   = -32'sd2731;
	localparam logic signed [31:0] C_M24X3 = -32'sd8193;
	localparam logic signed [31:0] C_120   = 32'sd546;
	localparam logic signed [31:0] C_120X4 = 32'sd2184;
	localparam logic signed [31:0] C_720   = 32'sd91;
	localparam logic signed [31:0] C_720X5 = 32'sd455;

	// angle constants in Q16.16
	localparam logic signed [19:0] PI_S      = 20'sd205887;
	localparam logic signed [19:0] HALF_PI_S = 20'sd102944;
	localparam logic signed [19:0] TWO_PI_S  = 20'sd411775;

	// 16384 turns, lifts any three-term angle sum above zero
	localparam logic signed [34:0] RED_OFS = 35'sd6746521600;

	// cordic constants, Q2.30
	localparam int CORDIC_STEPS = 24;
	localparam int CORDIC_LAT   = 19;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [31:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
		32'sd67021687, 32'sd33543516, 32'sd16775851, 32'sd8388437,
		32'sd4194283, 32'sd2097149, 32'sd1048576, 32'sd524288,
		32'sd262144, 32'sd131072, 32'sd65536, 32'sd32768,
		32'sd16384, 32'sd8192, 32'sd4096, 32'sd2048,
		32'sd1024, 32'sd512, 32'sd256, 32'sd128
	};

	// clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Q16.16 product, rounded half up, saturated
	function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		p = (p + 64'sd32768) >>> 16;
		return sat32(p);
	endfunction

	function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		return sat32(64'(s));
	endfunction

	function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] s;
		s = 33'(a) - 33'(b);
		return sat32(64'(s));
	endfunction

endpackage

// ----- rtl/ldtd_cordic.sv -----
// ldtd_cordic: pipelined sine and cosine of a Q16.16 angle sum
// range reduction by restoring subtraction, fold, 24-step rotation cordic; uses ldtd_pkg
module ldtd_cordic import ldtd_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic signed [33:0]  ang,
	output logic signed [31:0]  cos_val,
	output logic signed [31:0]  sin_val
);

	localparam int XW = 34;
	localparam int ZW = 33;
	localparam int RED_STG = 4;
	localparam int RED_STEP = 4;
	localparam int ROT_STG = CORDIC_STEPS / 2;

	logic [33:0] rem_q [RED_STG+1];
	logic [33:0] rem_nx [RED_STG];
	logic signed [XW-1:0] x_q [ROT_STG+1];
	logic signed [XW-1:0] y_q [ROT_STG+1];
	logic signed [ZW-1:0] z_q [ROT_STG+1];
	logic neg_q [ROT_STG+1];
	logic signed [31:0] cos_q, sin_q;

	// lift the angle above zero
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= 34'(35'(ang) + RED_OFS);
		end
	end

	// restoring remainder by 2pi, four quotient bits a stage
	for (genvar st = 0; st < RED_STG; st++) begin : g_red
		logic [33:0] t;
		always_comb begin
			t = rem_q[st];
			for (int k = 0; k < RED_STEP; k++) begin
				if (t >= (34'(TWO_PI_S) << (15 - RED_STEP*st - k))) begin
					t = t - (34'(TWO_PI_S) << (15 - RED_STEP*st - k));
				end
			end
			rem_nx[st] = t;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[st+1] <= rem_nx[st];
			end
		end
	end

	// wrap into (-pi, pi], fold into [-pi/2, pi/2]
	logic signed [19:0] r_f;
	logic neg_f;
	always_comb begin
		r_f = signed'({1'b0, rem_q[RED_STG][18:0]});
		neg_f = 1'b0;
		if (r_f > PI_S) begin
			r_f = r_f - TWO_PI_S;
		end
		if (r_f > HALF_PI_S) begin
			r_f = r_f - PI_S;
			neg_f = 1'b1;
		end else if (r_f < -HALF_PI_S) begin
			r_f = r_f + PI_S;
			neg_f = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0] <= CORDIC_GAIN;
			y_q[0] <= '0;
			z_q[0] <= ZW'(r_f) <<< 14;
			neg_q[0] <= neg_f;
		end
	end

	// rotation, two iterations a stage
	for (genvar s = 1; s <= ROT_STG; s++) begin : g_rot
		logic signed [XW-1:0] xt, yt, dx, dy;
		logic signed [ZW-1:0] zt;
		always_comb begin
			xt = x_q[s-1];
			yt = y_q[s-1];
			zt = z_q[s-1];
			for (int k = 0; k < 2; k++) begin
				dx = yt >>> (2*(s-1) + k);
				dy = xt >>> (2*(s-1) + k);
				if (zt >= 0) begin
					xt = xt - dx;
					yt = yt + dy;
					zt = zt - ZW'(ATAN_TAB[2*(s-1) + k]);
				end else begin
					xt = xt + dx;
					yt = yt - dy;
					zt = zt + ZW'(ATAN_TAB[2*(s-1) + k]);
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				x_q[s] <= xt;
				y_q[s] <= yt;
				z_q[s] <= zt;
				neg_q[s] <= neg_q[s-1];
			end
		end
	end

	// round to Q16.16 and undo the fold
	logic signed [XW-1:0] xr, yr;
	assign xr = (x_q[ROT_STG] + XW'(8192)) >>> 14;
	assign yr = (y_q[ROT_STG] + XW'(8192)) >>> 14;

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q <= neg_q[ROT_STG] ? -32'(xr) : 32'(xr);
			sin_q <= neg_q[ROT_STG] ? -32'(yr) : 32'(yr);
		end
	end

	assign cos_val = cos_q;
	assign sin_val = sin_q;

endmodule

// ----- rtl/lidar_beam_twist_deskew_top.sv -----
// lidar_beam_twist_deskew_top: deskews lidar beams under a constant twist, one beam a cycle
// when not stalled; uses ldtd_pkg and three ldtd_cordic units
//
// channel   dir  handshake              payload
// s_*       in   s_tvalid / s_tready    tdata: range_val, beam_angle, stamp; tuser: scan_start
// m_*       out  m_tvalid / m_tready    tdata: point_x, point_y, jacobian; tuser: point_valid
// cfg_*     in   cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// one beam accepted per cycle while the pipeline is not frozen
// the depth is set by the beam heading cordic unit (range reduction plus 24 rotations)
// reset clears configuration, the scan base and all valid bits; no clearing pass
// results sit in a two-entry output buffer; only a full skid entry freezes the pipeline
module lidar_beam_twist_deskew_top import ldtd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [95:0]   s_tdata,   // range_val[30:0], beam_angle[62:31], stamp[94:63], zero pad
	input  logic          s_tuser,   // scan_start
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [191:0]  m_tdata,   // point_x, point_y, dx_dlin, dx_dang, dy_dlin, dy_dang
	output logic          m_tuser,   // point_valid
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data
);

	localparam int SER_DLY  = CORDIC_LAT - 6;
	localparam int LAST_STG = CORDIC_LAT + 8;

	typedef struct packed {
		logic signed [31:0] rps, rpc, a00, a10, a01, a11, dt, rng;
		logic ok;
	} ser_t;

	typedef struct packed {
		logic pv;
		logic signed [31:0] x, y, j00, j01, j10, j11;
	} out_t;

	logic en;
	logic [LAST_STG:1] vld_q;

	// configuration registers
	logic signed [31:0] lin_vel_q, ang_vel_q, start_x_q, start_y_q;
	logic signed [31:0] start_hd_q, sensor_hd_q, sensor_x_q, sensor_y_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_vel_q <= '0;
			ang_vel_q <= '0;
			start_x_q <= '0;
			start_y_q <= '0;
			start_hd_q <= '0;
			sensor_hd_q <= '0;
			sensor_x_q <= '0;
			sensor_y_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LIN_VEL:        lin_vel_q <= cfg_data;
				REG_ANG_VEL:        ang_vel_q <= cfg_data;
				REG_START_X:        start_x_q <= cfg_data;
				REG_START_Y:        start_y_q <= cfg_data;
				REG_START_HEADING:  start_hd_q <= cfg_data;
				REG_SENSOR_HEADING: sensor_hd_q <= cfg_data;
				REG_SENSOR_X:       sensor_x_q <= cfg_data;
				REG_SENSOR_Y:       sensor_y_q <= cfg_data;
				default:            ;
			endcase
		end
	end

	// input request and scan base
	logic [30:0] in_range;
	logic signed [31:0] in_alpha, in_dt;
	logic [31:0] in_stamp, base_stamp_q;
	logic base_latched_q, in_start, in_acc;

	assign s_tready = en;
	assign in_acc = s_tvalid && en;
	assign in_range = s_tdata[30:0];
	assign in_alpha = s_tdata[62:31];
	assign in_stamp = s_tdata[94:63];
	assign in_start = s_tuser || !base_latched_q;
	assign in_dt = in_start ? '0 : signed'(in_stamp - base_stamp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_stamp_q <= '0;
			base_latched_q <= 1'b0;
		end else if (in_acc && in_start) begin
			base_stamp_q <= in_stamp;
			base_latched_q <= 1'b1;
		end
	end

	// valid bits travel with the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAST_STG-1:1], s_tvalid};
		end
	end

	// series part: s1 to s9
	logic signed [31:0] dt_s1, rng_s1, alpha_s1;
	logic ok_s1;
	logic signed [31:0] dt_s2, rng_s2, alpha_s2, rho_s2, th_s2;
	logic ok_s2;
	logic signed [31:0] dt_s3, rng_s3, rho_s3, th_s3, t2_s3, hth_s3, d1_s3;
	logic signed [33:0] ang_s3;
	logic ok_s3;
	logic signed [31:0] dt_s4, rng_s4, rho_s4, th_s4, t3_s4, hth_s4, d1_s4, p1_s4, p2_s4;
	logic ok_s4;
	logic signed [31:0] dt_s5, rng_s5, rho_s5, th_s5, t4_s5, hth_s5, d1_s5;
	logic signed [31:0] p1_s5, p2_s5, p3_s5, p4_s5;
	logic ok_s5;
	logic signed [31:0] dt_s6, rng_s6, rho_s6, t5_s6, hth_s6, d1_s6;
	logic signed [31:0] p1_s6, p2_s6, p3_s6, p4_s6, p5_s6, p6_s6;
	logic ok_s6;
	logic signed [31:0] dt_s7, rng_s7, rho_s7, hth_s7, p3_s7, p7_s7, ps_s7, dps_s7, dpc_s7;
	logic ok_s7;
	logic signed [31:0] dt_s8, rng_s8, rho_s8, pc_s8, rps_s8, a00_s8, e1_s8, e2_s8;
	logic ok_s8;
	ser_t ser_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			dt_s1 <= in_dt;
			rng_s1 <= signed'({1'b0, in_range});
			alpha_s1 <= in_alpha;
			ok_s1 <= in_range < MAX_RANGE;

			// travelled distance and turned angle
			dt_s2 <= dt_s1;
			rng_s2 <= rng_s1;
			alpha_s2 <= alpha_s1;
			ok_s2 <= ok_s1;
			rho_s2 <= qmul(lin_vel_q, dt_s1);
			th_s2 <= qmul(ang_vel_q, dt_s1);

			// powers of the turned angle and their terms
			dt_s3 <= dt_s2;
			rng_s3 <= rng_s2;
			ok_s3 <= ok_s2;
			rho_s3 <= rho_s2;
			th_s3 <= th_s2;
			t2_s3 <= qmul(th_s2, th_s2);
			hth_s3 <= qmul(Q_HALF, th_s2);
			d1_s3 <= qmul(C_M6X2, th_s2);
			ang_s3 <= 34'(alpha_s2) + 34'(start_hd_q) + 34'(th_s2);

			dt_s4 <= dt_s3;
			rng_s4 <= rng_s3;
			ok_s4 <= ok_s3;
			rho_s4 <= rho_s3;
			th_s4 <= th_s3;
			hth_s4 <= hth_s3;
			d1_s4 <= d1_s3;
			t3_s4 <= qmul(t2_s3, th_s3);
			p1_s4 <= qmul(C_M6, t2_s3);
			p2_s4 <= qmul(C_M24X3, t2_s3);

			dt_s5 <= dt_s4;
			rng_s5 <= rng_s4;
			ok_s5 <= ok_s4;
			rho_s5 <= rho_s4;
			th_s5 <= th_s4;
			hth_s5 <= hth_s4;
			d1_s5 <= d1_s4;
			p1_s5 <= p1_s4;
			p2_s5 <= p2_s4;
			t4_s5 <= qmul(t3_s4, th_s4);
			p3_s5 <= qmul(C_M24, t3_s4);
			p4_s5 <= qmul(C_120X4, t3_s4);

			dt_s6 <= dt_s5;
			rng_s6 <= rng_s5;
			ok_s6 <= ok_s5;
			rho_s6 <= rho_s5;
			hth_s6 <= hth_s5;
			d1_s6 <= d1_s5;
			p1_s6 <= p1_s5;
			p2_s6 <= p2_s5;
			p3_s6 <= p3_s5;
			p4_s6 <= p4_s5;
			t5_s6 <= qmul(t4_s5, th_s5);
			p5_s6 <= qmul(C_120, t4_s5);
			p6_s6 <= qmul(C_720X5, t4_s5);

			// sinc-like series and their derivatives
			dt_s7 <= dt_s6;
			rng_s7 <= rng_s6;
			ok_s7 <= ok_s6;
			rho_s7 <= rho_s6;
			hth_s7 <= hth_s6;
			p3_s7 <= p3_s6;
			p7_s7 <= qmul(C_720, t5_s6);
			ps_s7 <= qadd(qadd(Q_ONE, p1_s6), p5_s6);
			dps_s7 <= qadd(d1_s6, p4_s6);
			dpc_s7 <= qadd(qadd(Q_HALF, p2_s6), p6_s6);

			dt_s8 <= dt_s7;
			rng_s8 <= rng_s7;
			ok_s8 <= ok_s7;
			rho_s8 <= rho_s7;
			pc_s8 <= qadd(qadd(hth_s7, p3_s7), p7_s7);
			rps_s8 <= qmul(rho_s7, ps_s7);
			a00_s8 <= qmul(dt_s7, ps_s7);
			e1_s8 <= qmul(dt_s7, dps_s7);
			e2_s8 <= qmul(dt_s7, dpc_s7);

			ser_s9.dt <= dt_s8;
			ser_s9.rng <= rng_s8;
			ser_s9.ok <= ok_s8;
			ser_s9.rps <= rps_s8;
			ser_s9.a00 <= a00_s8;
			ser_s9.rpc <= qmul(rho_s8, pc_s8);
			ser_s9.a10 <= qmul(dt_s8, pc_s8);
			ser_s9.a01 <= qmul(e1_s8, rho_s8);
			ser_s9.a11 <= qmul(e2_s8, rho_s8);
		end
	end

	// hold series results until the cordic units catch up
	ser_t ser_dly_q [SER_DLY];
	always_ff @(posedge clk) begin
		if (en) begin
			ser_dly_q[0] <= ser_s9;
			for (int k = 1; k < SER_DLY; k++) begin
				ser_dly_q[k] <= ser_dly_q[k-1];
			end
		end
	end

	ser_t ser_c;
	assign ser_c = ser_dly_q[SER_DLY-1];

	// sines and cosines of start heading, beam heading and sensor heading
	logic signed [31:0] c0, s0, cb, sb, cs, ss;

	ldtd_cordic u_cordic_start (
		.clk(clk), .en(en), .ang(34'(start_hd_q)), .cos_val(c0), .sin_val(s0)
	);
	ldtd_cordic u_cordic_beam (
		.clk(clk), .en(en), .ang(ang_s3), .cos_val(cb), .sin_val(sb)
	);
	ldtd_cordic u_cordic_sensor (
		.clk(clk), .en(en), .ang(34'(sensor_hd_q)), .cos_val(cs), .sin_val(ss)
	);

	// geometry: s23 to s27
	logic signed [31:0] k_s23 [4];
	logic signed [31:0] l_s23 [4];
	logic signed [31:0] m_s23 [4];
	logic signed [31:0] rc_s23, rs_s23, dt_s23, cs_s23, ss_s23;
	logic ok_s23;
	logic signed [31:0] px_s24, py_s24, b00_s24, b10_s24, b01_s24, b11_s24;
	logic signed [31:0] rc_s24, rs_s24, rsdt_s24, rcdt_s24, cs_s24, ss_s24;
	logic ok_s24;
	logic signed [31:0] qx_s25, qy_s25, u0_s25, u1_s25, b00_s25, b10_s25, cs_s25, ss_s25;
	logic ok_s25;
	logic signed [31:0] n_s26 [4];
	logic signed [31:0] o_s26 [4];
	logic signed [31:0] w_s26 [4];
	logic ok_s26;
	out_t res_s27;

	always_ff @(posedge clk) begin
		if (en) begin
			// start heading rotation products and beam offset
			k_s23[0] <= qmul(c0, ser_c.rps);
			k_s23[1] <= qmul(s0, ser_c.rpc);
			k_s23[2] <= qmul(s0, ser_c.rps);
			k_s23[3] <= qmul(c0, ser_c.rpc);
			l_s23[0] <= qmul(c0, ser_c.a00);
			l_s23[1] <= qmul(s0, ser_c.a10);
			l_s23[2] <= qmul(s0, ser_c.a00);
			l_s23[3] <= qmul(c0, ser_c.a10);
			m_s23[0] <= qmul(c0, ser_c.a01);
			m_s23[1] <= qmul(s0, ser_c.a11);
			m_s23[2] <= qmul(s0, ser_c.a01);
			m_s23[3] <= qmul(c0, ser_c.a11);
			rc_s23 <= qmul(ser_c.rng, cb);
			rs_s23 <= qmul(ser_c.rng, sb);
			dt_s23 <= ser_c.dt;
			ok_s23 <= ser_c.ok;
			cs_s23 <= cs;
			ss_s23 <= ss;

			px_s24 <= qsub(k_s23[0], k_s23[1]);
			py_s24 <= qadd(k_s23[2], k_s23[3]);
			b00_s24 <= qsub(l_s23[0], l_s23[1]);
			b10_s24 <= qadd(l_s23[2], l_s23[3]);
			b01_s24 <= qsub(m_s23[0], m_s23[1]);
			b11_s24 <= qadd(m_s23[2], m_s23[3]);
			rsdt_s24 <= qmul(rs_s23, dt_s23);
			rcdt_s24 <= qmul(rc_s23, dt_s23);
			rc_s24 <= rc_s23;
			rs_s24 <= rs_s23;
			ok_s24 <= ok_s23;
			cs_s24 <= cs_s23;
			ss_s24 <= ss_s23;

			// endpoint in world frame and angular column before sensor rotation
			qx_s25 <= qadd(qadd(start_x_q, px_s24), rc_s24);
			qy_s25 <= qadd(qadd(start_y_q, py_s24), rs_s24);
			u0_s25 <= qsub(b01_s24, rsdt_s24);
			u1_s25 <= qadd(b11_s24, rcdt_s24);
			b00_s25 <= b00_s24;
			b10_s25 <= b10_s24;
			ok_s25 <= ok_s24;
			cs_s25 <= cs_s24;
			ss_s25 <= ss_s24;

			// sensor rotation products
			n_s26[0] <= qmul(cs_s25, qx_s25);
			n_s26[1] <= qmul(ss_s25, qy_s25);
			n_s26[2] <= qmul(ss_s25, qx_s25);
			n_s26[3] <= qmul(cs_s25, qy_s25);
			o_s26[0] <= qmul(cs_s25, b00_s25);
			o_s26[1] <= qmul(ss_s25, b10_s25);
			o_s26[2] <= qmul(ss_s25, b00_s25);
			o_s26[3] <= qmul(cs_s25, b10_s25);
			w_s26[0] <= qmul(cs_s25, u0_s25);
			w_s26[1] <= qmul(ss_s25, u1_s25);
			w_s26[2] <= qmul(ss_s25, u0_s25);
			w_s26[3] <= qmul(cs_s25, u1_s25);
			ok_s26 <= ok_s25;

			// final sums, zeroed for out-of-range beams
			res_s27.pv <= ok_s26;
			res_s27.x <= ok_s26 ? qadd(sensor_x_q, qsub(n_s26[0], n_s26[1])) : '0;
			res_s27.y <= ok_s26 ? qadd(sensor_y_q, qadd(n_s26[2], n_s26[3])) : '0;
			res_s27.j00 <= ok_s26 ? qsub(o_s26[0], o_s26[1]) : '0;
			res_s27.j10 <= ok_s26 ? qadd(o_s26[2], o_s26[3]) : '0;
			res_s27.j01 <= ok_s26 ? qsub(w_s26[0], w_s26[1]) : '0;
			res_s27.j11 <= ok_s26 ? qadd(w_s26[2], w_s26[3]) : '0;
		end
	end

	// two-entry output buffer
	out_t out_q, skid_q;
	logic out_vld_q, skid_vld_q, out_take, res_in, load_out, load_skid, pop_skid;

	assign en = !skid_vld_q;
	assign out_take = out_vld_q && m_tready;
	assign res_in = en && vld_q[LAST_STG];
	assign pop_skid = out_take && skid_vld_q;
	assign load_out = res_in && (!out_vld_q || out_take);
	assign load_skid = res_in && out_vld_q && !out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (pop_skid) begin
				skid_vld_q <= 1'b0;
			end else if (load_skid) begin
				skid_vld_q <= 1'b1;
			end
			if (pop_skid || load_out) begin
				out_vld_q <= 1'b1;
			end else if (out_take) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_skid) begin
			out_q <= skid_q;
		end else if (load_out) begin
			out_q <= res_s27;
		end
		if (load_skid) begin
			skid_q <= res_s27;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser = out_q.pv;
	assign m_tdata = {out_q.j11, out_q.j10, out_q.j01, out_q.j00, out_q.y, out_q.x};

`ifndef SYNTHESIS
	// skid entry only fills behind a held result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry holds a result while the output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !m_tready))
		else $error("skid entry filled although the output moved");

	a_base_latched: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> base_latched_q)
		else $error("scan base not latched after a beam request");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[LAST_STG] && !en) |=> vld_q[LAST_STG])
		else $error("last pipeline stage lost its result during a stall");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("out-of-range beam carries nonzero point or jacobian");
`endif

endmodule
